// ===== src/bctl_pkg.sv =====
// Package for the block cache tag and LRU manager.
// Operation and status codes and default sizes; no dependencies.
`default_nettype none
package bctl_pkg;
   localparam int ENTRIES_DEF = 32;

   typedef enum logic [1:0] {
      FN_GET   = 2'd0,
      FN_CHECK = 2'd1,
      FN_PUT   = 2'd2,
      FN_SYNC  = 2'd3
   } func_type;

   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_MISS     = 3'd1;
   localparam logic [2:0] ST_NOFREE   = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_NEGBLK   = 3'd4;
   localparam logic [2:0] ST_DONE     = 3'd5;
   localparam logic [2:0] ST_RELEASED = 3'd6;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_LINK   = 7'b0001000,
      S_EMIT   = 7'b0010000,
      S_SYNC   = 7'b0100000,
      S_SYNCO  = 7'b1000000
   } state_type;
endpackage
`default_nettype wire

// ===== src/bctl_match.sv =====
// Tag comparator shared by lookups and the sync walk.
// Depends on bctl_pkg.
`default_nettype none
module bctl_match
   import bctl_pkg::*;
(
   input  wire logic [15:0] tag_dev,
   input  wire logic [31:0] tag_blk,
   input  wire logic [15:0] key_dev,
   input  wire logic [31:0] key_blk,
   input  wire logic        dev_only,
   output logic             hit
);
   assign hit = (tag_dev == key_dev) && (dev_only || (tag_blk == key_blk));
endmodule
`default_nettype wire

// ===== src/block_cache_tag_lru_manager.sv =====
// Block cache tag and LRU free-list manager, top level.
// Uses bctl_pkg and bctl_match (one comparator walked over all entries).
//
// Usage: one request word on req_* (valid/ready); results on rsp_* (valid/ready).
// get/check: a sequencer walks entries one per cycle through a single tag
// comparator, then decides, relinks the LRU list on a hit or a miss, and
// emits; a negative block is answered without a walk. put: decides,
// relinks unless the entry is already free or the index is invalid, and emits.
// sync: walks all entries and emits a single done word when nothing is written;
// each write-back word is held back one step so that the final one can carry
// rsp_last, and the walk pauses while a word waits on rsp_ready.
// req_ready is high only when the block is idle and no word is waiting, so
// the next request is taken after the final word of the last one is taken.
// A stalled receiver simply holds the walk and the output word.
// Reset (synchronous) tags all entries invalid, clean, and links them
// 0..ENTRIES-1 on the free list.
`default_nettype none
module block_cache_tag_lru_manager
   import bctl_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_device_id,
   input  wire logic signed [31:0] req_block_number,
   input  wire logic signed [6:0]  req_entry_index,
   input  wire logic signed [1:0]  req_dirty_request,
   input  wire logic        req_unmount_flag,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [6:0] rsp_granted_entry,
   output logic [2:0]       rsp_status,
   output logic             rsp_writeback_valid,
   output logic [15:0]      rsp_writeback_device,
   output logic [30:0]      rsp_writeback_block,
   output logic             rsp_fill_valid,
   output logic             rsp_last
);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = IW + 1;

   logic [15:0] tdev_ff [ENTRIES];
   logic [31:0] tblk_ff [ENTRIES];
   logic [ENTRIES-1:0] dirty_ff, onfree_ff;
   logic [IW-1:0] nxt_ff [ENTRIES];
   logic [IW-1:0] prv_ff [ENTRIES];
   logic [IW-1:0] head_ff;
   logic empty_ff;

   state_type st_ff;
   func_type fn_ff;
   logic [15:0] dev_ff;
   logic [31:0] blk_ff;
   logic [6:0]  idx_ff;
   logic [1:0]  dreq_ff;
   logic        um_ff;
   logic [CW-1:0] cnt_ff;
   logic        found_ff;
   logic [IW-1:0] hit_ff;
   logic        any_ff;
   logic [IW-1:0] tgt_ff;

   logic signed [6:0] o_ent_ff;
   logic [2:0]  o_st_ff;
   logic        o_wb_ff, o_fill_ff, o_last_ff, o_v_ff;
   logic [15:0] o_wd_ff;
   logic [30:0] o_wbk_ff;

   logic [IW-1:0] ci;
   logic m_hit;
   assign ci = cnt_ff[IW-1:0];

   bctl_match u_match (
      .tag_dev(tdev_ff[ci]), .tag_blk(tblk_ff[ci]),
      .key_dev(dev_ff), .key_blk(blk_ff),
      .dev_only(fn_ff == FN_SYNC), .hit(m_hit)
   );

   assign req_ready = (st_ff == S_IDLE) && !o_v_ff;
   assign rsp_valid = o_v_ff;
   assign rsp_granted_entry = o_ent_ff;
   assign rsp_status = o_st_ff;
   assign rsp_writeback_valid = o_wb_ff;
   assign rsp_writeback_device = o_wd_ff;
   assign rsp_writeback_block = o_wbk_ff;
   assign rsp_fill_valid = o_fill_ff;
   assign rsp_last = o_last_ff;

   logic out_free;
   assign out_free = !o_v_ff || rsp_ready;

   logic sync_wb, sync_end, o_load;
   assign sync_wb = m_hit && dirty_ff[ci] && !tblk_ff[ci][31];
   assign sync_end = (cnt_ff == CW'(ENTRIES - 1));
   // a word is presented at these edges
   assign o_load = ((st_ff == S_EMIT) && out_free) ||
                   ((st_ff == S_SYNC) && !sync_wb && sync_end && any_ff && out_free) ||
                   ((st_ff == S_SYNCO) && any_ff && out_free);

   logic [IW-1:0] u_nx, u_pv, h_tail;
   assign u_nx = nxt_ff[tgt_ff];
   assign u_pv = prv_ff[tgt_ff];
   assign h_tail = prv_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (o_load) begin
         o_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         o_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         head_ff <= '0;
         empty_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            tdev_ff[i] <= '0;
            tblk_ff[i] <= '1;
            dirty_ff[i] <= 1'b0;
            onfree_ff[i] <= 1'b1;
            nxt_ff[i] <= IW'((i + 1) % ENTRIES);
            prv_ff[i] <= IW'((i + ENTRIES - 1) % ENTRIES);
         end
      end else begin
         unique case (st_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  fn_ff <= func_type'(req_func);
                  dev_ff <= req_device_id;
                  blk_ff <= req_block_number;
                  idx_ff <= req_entry_index;
                  dreq_ff <= req_dirty_request;
                  um_ff <= req_unmount_flag;
                  cnt_ff <= '0;
                  found_ff <= 1'b0;
                  any_ff <= 1'b0;
                  o_wb_ff <= 1'b0; o_wd_ff <= '0; o_wbk_ff <= '0;
                  o_fill_ff <= 1'b0; o_last_ff <= 1'b1;
                  if (func_type'(req_func) == FN_SYNC) st_ff <= S_SYNC;
                  else if (func_type'(req_func) == FN_PUT) st_ff <= S_DECIDE;
                  else if (req_block_number[31]) begin
                     o_ent_ff <= -7'sd1; o_st_ff <= ST_NEGBLK; st_ff <= S_EMIT;
                  end else st_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (m_hit && !found_ff) begin
                  found_ff <= 1'b1; hit_ff <= ci;
               end
               if (cnt_ff == CW'(ENTRIES - 1)) st_ff <= S_DECIDE;
               else cnt_ff <= cnt_ff + 1'b1;
            end
            S_DECIDE: begin
               if (fn_ff == FN_PUT) begin
                  if (idx_ff[6] || idx_ff >= 7'(ENTRIES)) begin
                     o_ent_ff <= -7'sd1; o_st_ff <= ST_DONE; st_ff <= S_EMIT;
                  end else begin
                     tgt_ff <= idx_ff[IW-1:0];
                     o_ent_ff <= idx_ff;
                     if (dreq_ff == 2'd1) dirty_ff[idx_ff[IW-1:0]] <= 1'b1;
                     else if (dreq_ff[1]) dirty_ff[idx_ff[IW-1:0]] <= 1'b0;
                     if (onfree_ff[idx_ff[IW-1:0]]) begin
                        o_st_ff <= ST_RELEASED; st_ff <= S_EMIT;
                     end else begin o_st_ff <= ST_DONE; st_ff <= S_LINK; end
                  end
               end else if (found_ff) begin
                  tgt_ff <= hit_ff; o_ent_ff <= 7'(hit_ff); o_st_ff <= ST_HIT;
                  st_ff <= S_LINK;
               end else if (fn_ff == FN_CHECK) begin
                  o_ent_ff <= -7'sd1; o_st_ff <= ST_NOTFOUND; st_ff <= S_EMIT;
               end else if (empty_ff) begin
                  o_ent_ff <= -7'sd1; o_st_ff <= ST_NOFREE; st_ff <= S_EMIT;
               end else begin
                  tgt_ff <= head_ff; o_ent_ff <= 7'(head_ff); o_st_ff <= ST_MISS;
                  o_fill_ff <= 1'b1;
                  if (dirty_ff[head_ff] && !tblk_ff[head_ff][31]) begin
                     o_wb_ff <= 1'b1; o_wd_ff <= tdev_ff[head_ff];
                     o_wbk_ff <= tblk_ff[head_ff][30:0];
                  end
                  dirty_ff[head_ff] <= 1'b0;
                  tdev_ff[head_ff] <= dev_ff;
                  tblk_ff[head_ff] <= blk_ff;
                  st_ff <= S_LINK;
               end
            end
            S_LINK: begin
               st_ff <= S_EMIT;
               if (fn_ff == FN_PUT) begin
                  if (empty_ff) begin
                     head_ff <= tgt_ff; nxt_ff[tgt_ff] <= tgt_ff;
                     prv_ff[tgt_ff] <= tgt_ff; empty_ff <= 1'b0;
                  end else begin
                     prv_ff[tgt_ff] <= h_tail; nxt_ff[tgt_ff] <= head_ff;
                     nxt_ff[h_tail] <= tgt_ff; prv_ff[head_ff] <= tgt_ff;
                  end
                  onfree_ff[tgt_ff] <= 1'b1;
               end else if (onfree_ff[tgt_ff]) begin
                  if (head_ff == tgt_ff) begin
                     if (u_nx == tgt_ff) empty_ff <= 1'b1;
                     else head_ff <= u_nx;
                  end
                  prv_ff[u_nx] <= u_pv;
                  nxt_ff[u_pv] <= u_nx;
                  onfree_ff[tgt_ff] <= 1'b0;
               end
            end
            S_EMIT: begin
               if (out_free) st_ff <= S_IDLE;
            end
            S_SYNC: begin
               if (m_hit) begin
                  if (um_ff) tdev_ff[ci] <= '0;
                  dirty_ff[ci] <= 1'b0;
               end
               if (sync_wb) begin
                  // hold this write-back; emit previous one first
                  tgt_ff <= ci;
                  st_ff <= S_SYNCO;
               end else if (sync_end) begin
                  if (!any_ff) begin
                     o_ent_ff <= -7'sd1; o_st_ff <= ST_DONE; o_wb_ff <= 1'b0;
                     o_wd_ff <= '0; o_wbk_ff <= '0; o_last_ff <= 1'b1;
                     st_ff <= S_EMIT;
                  end else if (out_free) begin
                     // held word is the final one
                     o_ent_ff <= 7'(hit_ff); o_st_ff <= ST_DONE; o_wb_ff <= 1'b1;
                     o_wd_ff <= dev_ff; o_wbk_ff <= tblk_ff[hit_ff][30:0];
                     o_last_ff <= 1'b1; st_ff <= S_IDLE;
                  end
               end else cnt_ff <= cnt_ff + 1'b1;
            end
            S_SYNCO: begin
               // pending word goes out (not last) before the new one is held
               if (!any_ff || out_free) begin
                  if (any_ff) begin
                     o_ent_ff <= 7'(hit_ff); o_st_ff <= ST_DONE; o_wb_ff <= 1'b1;
                     o_wd_ff <= dev_ff; o_wbk_ff <= tblk_ff[hit_ff][30:0];
                     o_last_ff <= 1'b0;
                  end
                  any_ff <= 1'b1;
                  hit_ff <= tgt_ff;
                  if (!sync_end) cnt_ff <= cnt_ff + 1'b1;
                  st_ff <= S_SYNC;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // final-entry handling: after the last write-back is held, S_SYNC at last
   // index re-checks the entry whose dirty mark is now clear, so it finishes.

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> st_ff == S_IDLE) else $error("ready outside idle");
   a_fill_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fill_valid) |-> rsp_status == ST_MISS)
      else $error("fill without miss");
   a_wb_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> rsp_writeback_valid)
      else $error("non-final word without write-back");
endmodule
`default_nettype wire
